// ===== design/rti_pkg.sv =====
// Shared types, constants and saturating helpers for the ray/triangle core.
`timescale 1ns / 1ps
package rti_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int INNER_W    = 56;
	localparam int EDGE_W     = COORD_W + 1;
	localparam int EPS_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int MUL_LAT    = 2;
	localparam int DIV_STEPS  = INNER_W;
	localparam int DIV_LAT    = DIV_STEPS + 2;
	// queue head to result register
	localparam int PIPE_LAT   = 10 + DIV_LAT + 1 + MUL_LAT + 1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CULL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EPS  = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;
	typedef logic signed [INNER_W-1:0] inner_t;

	localparam inner_t IN_MAX = {1'b0, {(INNER_W-1){1'b1}}};
	localparam inner_t IN_MIN = {1'b1, {(INNER_W-1){1'b0}}};
	localparam coord_t CO_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t CO_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic       command;
		logic [1:0] vertex_select;
		coord_t     pos_x;
		coord_t     pos_y;
		coord_t     pos_z;
		coord_t     dir_x;
		coord_t     dir_y;
		coord_t     dir_z;
		coord_t     t_lower;
		coord_t     t_upper;
	} req_t;

	typedef struct packed {
		logic   hit;
		coord_t hit_distance;
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		coord_t normal_x;
		coord_t normal_y;
		coord_t normal_z;
	} rsp_t;

	typedef struct packed {
		logic             cull_backfaces;
		logic [EPS_W-1:0] det_epsilon;
	} cfg_t;

	// one queued test: ray plus edges taken from the vertex store at accept
	typedef struct packed {
		coord_t [2:0] o;
		coord_t [2:0] d;
		coord_t       tl;
		coord_t       tu;
		edge_t  [2:0] e1;
		edge_t  [2:0] e2;
		edge_t  [2:0] tv;
	} qent_t;

	function automatic inner_t ext_coord(coord_t c);
		return {{(INNER_W-COORD_W){c[COORD_W-1]}}, c};
	endfunction

	function automatic inner_t ext_edge(edge_t e);
		return {{(INNER_W-EDGE_W){e[EDGE_W-1]}}, e};
	endfunction

	function automatic inner_t sat_add(inner_t a, inner_t b);
		logic [INNER_W:0] s;
		s = {a[INNER_W-1], a} + {b[INNER_W-1], b};
		if (s[INNER_W] != s[INNER_W-1])
			return s[INNER_W] ? IN_MIN : IN_MAX;
		return s[INNER_W-1:0];
	endfunction

	function automatic inner_t sat_sub(inner_t a, inner_t b);
		logic [INNER_W:0] s;
		s = {a[INNER_W-1], a} - {b[INNER_W-1], b};
		if (s[INNER_W] != s[INNER_W-1])
			return s[INNER_W] ? IN_MIN : IN_MAX;
		return s[INNER_W-1:0];
	endfunction

	function automatic inner_t sat_neg(inner_t a);
		return sat_sub('0, a);
	endfunction

	function automatic coord_t clamp_coord(inner_t x);
		logic [INNER_W-COORD_W:0] hi;
		hi = x[INNER_W-1:COORD_W-1];
		if ((&hi) || !(|hi))
			return x[COORD_W-1:0];
		return x[INNER_W-1] ? CO_MIN : CO_MAX;
	endfunction

endpackage

// ===== design/rti_mul.sv =====
// Two-stage saturating fixed-point multiplier built from four partial products.
`timescale 1ns / 1ps
module rti_mul import rti_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  inner_t a,
	input  inner_t b,
	output inner_t p
);

	localparam int LO_W   = INNER_W / 2;
	localparam int HI_W   = INNER_W - LO_W;
	localparam int PP_W   = 2 * HI_W;
	localparam int FULL_W = 2 * INNER_W;

	logic [INNER_W-1:0] ma, mb;
	logic [PP_W-1:0]    pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic               neg_s1;
	logic [FULL_W-1:0]  full, sh, cap;
	inner_t             res, p_s2;

	assign ma = a[INNER_W-1] ? INNER_W'(-a) : a;
	assign mb = b[INNER_W-1] ? INNER_W'(-b) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= PP_W'(ma[LO_W-1:0]) * PP_W'(mb[LO_W-1:0]);
			pp01_s1 <= PP_W'(ma[LO_W-1:0]) * PP_W'(mb[INNER_W-1:LO_W]);
			pp10_s1 <= PP_W'(ma[INNER_W-1:LO_W]) * PP_W'(mb[LO_W-1:0]);
			pp11_s1 <= PP_W'(ma[INNER_W-1:LO_W]) * PP_W'(mb[INNER_W-1:LO_W]);
			neg_s1  <= a[INNER_W-1] ^ b[INNER_W-1];
		end
	end

	always_comb begin
		full = FULL_W'(pp00_s1) + (FULL_W'(pp01_s1) << LO_W)
			+ (FULL_W'(pp10_s1) << LO_W) + (FULL_W'(pp11_s1) << (2 * LO_W));
		sh   = full >> FRAC_W;
		cap  = neg_s1 ? (FULL_W'(1) << (INNER_W - 1))
			: ((FULL_W'(1) << (INNER_W - 1)) - FULL_W'(1));
		if (sh > cap)
			sh = cap;
		res  = neg_s1 ? inner_t'(FULL_W'(-sh)) : inner_t'(sh);
	end

	always_ff @(posedge clk) begin
		if (en)
			p_s2 <= res;
	end

	assign p = p_s2;

endmodule

// ===== design/rti_div.sv =====
// Pipelined restoring divider: (n << FRAC_W) / d, one quotient bit per stage.
`timescale 1ns / 1ps
module rti_div import rti_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  inner_t n,
	input  inner_t d,
	output inner_t q
);

	logic [INNER_W-1:0] rem_q [DIV_STEPS+1];
	logic [INNER_W-1:0] quo_q [DIV_STEPS+1];
	logic [INNER_W-1:0] lo_q  [DIV_STEPS+1];
	logic [INNER_W-1:0] d_q   [DIV_STEPS+1];
	logic               neg_q [DIV_STEPS+1];
	logic               ovf_q [DIV_STEPS+1];

	logic [INNER_W-1:0] rem_d [DIV_STEPS+1];
	logic [INNER_W-1:0] quo_d [DIV_STEPS+1];
	logic [INNER_W-1:0] nm, mag, cap;
	logic [INNER_W:0]   trial;
	logic               ge;
	inner_t             q_q;

	assign nm = n[INNER_W-1] ? INNER_W'(-n) : n;

	always_comb begin
		rem_d[0] = nm >> (INNER_W - FRAC_W);
		quo_d[0] = '0;
		for (int i = 1; i <= DIV_STEPS; i++) begin
			trial    = {rem_q[i-1], lo_q[i-1][INNER_W-1]};
			ge       = trial >= {1'b0, d_q[i-1]};
			rem_d[i] = ge ? INNER_W'(trial - {1'b0, d_q[i-1]}) : trial[INNER_W-1:0];
			quo_d[i] = {quo_q[i-1][INNER_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem_d[0];
			quo_q[0] <= quo_d[0];
			lo_q[0]  <= nm << FRAC_W;
			d_q[0]   <= d;
			neg_q[0] <= n[INNER_W-1];
			// quotient would need more than INNER_W bits
			ovf_q[0] <= rem_d[0] >= d;
			for (int i = 1; i <= DIV_STEPS; i++) begin
				rem_q[i] <= rem_d[i];
				quo_q[i] <= quo_d[i];
				lo_q[i]  <= lo_q[i-1] << 1;
				d_q[i]   <= d_q[i-1];
				neg_q[i] <= neg_q[i-1];
				ovf_q[i] <= ovf_q[i-1];
			end
		end
	end

	always_comb begin
		cap = neg_q[DIV_STEPS] ? (INNER_W'(1) << (INNER_W - 1))
			: ((INNER_W'(1) << (INNER_W - 1)) - INNER_W'(1));
		mag = quo_q[DIV_STEPS];
		if (ovf_q[DIV_STEPS] || mag > cap)
			mag = cap;
	end

	always_ff @(posedge clk) begin
		if (en)
			q_q <= neg_q[DIV_STEPS] ? inner_t'(-mag) : inner_t'(mag);
	end

	assign q = q_q;

endmodule

// ===== design/rti_front.sv =====
// Front end: takes request words, keeps the vertex store, queues ray tests.
`timescale 1ns / 1ps
module rti_front import rti_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  req_t  req,
	output logic  req_stall,
	input  logic  full,
	output logic  push,
	output qent_t entry
);

	coord_t [2:0] vtx_q [3];
	logic         accept;

	function automatic edge_t dif(coord_t a, coord_t b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	assign req_stall = full;
	assign accept    = req_valid && !full;
	assign push      = accept && (req.command == CMD_TEST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				vtx_q[k] <= '0;
		end else if (accept && req.command == CMD_LOAD && req.vertex_select != 2'd3) begin
			vtx_q[req.vertex_select] <= {req.pos_z, req.pos_y, req.pos_x};
		end
	end

	always_comb begin
		entry.o  = {req.pos_z, req.pos_y, req.pos_x};
		entry.d  = {req.dir_z, req.dir_y, req.dir_x};
		entry.tl = req.t_lower;
		entry.tu = req.t_upper;
		for (int k = 0; k < 3; k++) begin
			entry.e1[k] = dif(vtx_q[1][k], vtx_q[0][k]);
			entry.e2[k] = dif(vtx_q[2][k], vtx_q[0][k]);
			entry.tv[k] = dif(entry.o[k], vtx_q[0][k]);
		end
	end

endmodule

// ===== design/rti_back.sv =====
// Back end: crosses, dots, face/barycentric tests, divide, hit point.
`timescale 1ns / 1ps
module rti_back import rti_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  head_valid,
	input  qent_t head,
	output logic  take,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	localparam int N_XMUL = 18;
	localparam int N_YMUL = 12;
	localparam int N_ZMUL = 3;
	localparam int DET = 0;
	localparam int UN  = 1;
	localparam int VN  = 2;
	localparam int TN  = 3;
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	typedef struct packed {
		coord_t [2:0] o;
		coord_t [2:0] d;
		coord_t       tl;
		coord_t       tu;
		inner_t [2:0] n;
	} carry_t;

	typedef struct packed {
		qent_t        e;
		inner_t [2:0] p;
		inner_t [2:0] q;
		inner_t [2:0] n;
	} s4_t;

	typedef struct packed {
		carry_t       c;
		inner_t [3:0] ab;
		inner_t [3:0] cc;
	} s7_t;

	typedef struct packed {
		carry_t       c;
		inner_t [3:0] sum;
	} s8_t;

	typedef struct packed {
		carry_t c;
		logic   ok;
		inner_t det;
		inner_t un;
		inner_t vn;
		inner_t tn;
	} s9_t;

	typedef struct packed {
		carry_t c;
		logic   ok;
		inner_t det;
		inner_t tn;
	} s10_t;

	typedef struct packed {
		carry_t c;
		logic   ok;
	} side_t;

	typedef struct packed {
		coord_t [2:0] o;
		coord_t [2:0] d;
		inner_t [2:0] n;
		logic         ok;
		inner_t       t;
	} tail_t;

	logic en;
	logic [PIPE_LAT-1:0] vld_q;

	qent_t  e_s1, e_s2, e_s3;
	s4_t    r_s4;
	carry_t c_s5, c_s6;
	s7_t    r_s7;
	s8_t    r_s8;
	s9_t    r_s9;
	s10_t   r_s10;
	side_t  side_q [DIV_LAT];
	tail_t  r_s69, r_s70, r_s71;
	rsp_t   rsp_q;

	inner_t xa [N_XMUL], xb [N_XMUL], xp [N_XMUL];
	inner_t ya [N_YMUL], yb [N_YMUL], yp [N_YMUL];
	inner_t za [N_ZMUL], zb [N_ZMUL], zp [N_ZMUL];
	inner_t t_div;

	s4_t   n_s4;
	s9_t   n_s9;
	s10_t  n_s10;
	tail_t n_s69;
	rsp_t  n_rsp;

	assign en        = !(rsp_valid && rsp_stall);
	assign take      = en;
	assign rsp_valid = vld_q[PIPE_LAT-1];
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_LAT-2:0], head_valid};
	end

	// cross products: d x e2, tv x e1, e1 x e2
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			xa[k*2]       = ext_coord(e_s1.d[NXT[k]]);
			xb[k*2]       = ext_edge(e_s1.e2[PRV[k]]);
			xa[k*2+1]     = ext_coord(e_s1.d[PRV[k]]);
			xb[k*2+1]     = ext_edge(e_s1.e2[NXT[k]]);
			xa[6+k*2]     = ext_edge(e_s1.tv[NXT[k]]);
			xb[6+k*2]     = ext_edge(e_s1.e1[PRV[k]]);
			xa[6+k*2+1]   = ext_edge(e_s1.tv[PRV[k]]);
			xb[6+k*2+1]   = ext_edge(e_s1.e1[NXT[k]]);
			xa[12+k*2]    = ext_edge(e_s1.e1[NXT[k]]);
			xb[12+k*2]    = ext_edge(e_s1.e2[PRV[k]]);
			xa[12+k*2+1]  = ext_edge(e_s1.e1[PRV[k]]);
			xb[12+k*2+1]  = ext_edge(e_s1.e2[NXT[k]]);
		end
		n_s4.e = e_s3;
		for (int k = 0; k < 3; k++) begin
			n_s4.p[k] = sat_sub(xp[k*2], xp[k*2+1]);
			n_s4.q[k] = sat_sub(xp[6+k*2], xp[6+k*2+1]);
			n_s4.n[k] = sat_sub(xp[12+k*2], xp[12+k*2+1]);
		end
	end

	// dot products: det, u*det, v*det, t*det
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ya[DET*3+k] = ext_edge(r_s4.e.e1[k]);
			yb[DET*3+k] = r_s4.p[k];
			ya[UN*3+k]  = ext_edge(r_s4.e.tv[k]);
			yb[UN*3+k]  = r_s4.p[k];
			ya[VN*3+k]  = ext_coord(r_s4.e.d[k]);
			yb[VN*3+k]  = r_s4.q[k];
			ya[TN*3+k]  = ext_edge(r_s4.e.e2[k]);
			yb[TN*3+k]  = r_s4.q[k];
		end
	end

	// face test; two-sided mode flips the sign of a negative determinant and of its u, v and t numerators
	always_comb begin
		inner_t det, un, vn, tn, eps_i, neps;
		logic   nz, ok;
		det   = r_s8.sum[DET];
		un    = r_s8.sum[UN];
		vn    = r_s8.sum[VN];
		tn    = r_s8.sum[TN];
		eps_i = {{(INNER_W-EPS_W){1'b0}}, cfg.det_epsilon};
		neps  = -eps_i;
		nz    = det != '0;
		if (cfg.cull_backfaces) begin
			ok = nz && det >= eps_i;
		end else begin
			ok = nz && (det >= eps_i || det <= neps);
			if (det < 0) begin
				det = sat_neg(det);
				un  = sat_neg(un);
				vn  = sat_neg(vn);
				tn  = sat_neg(tn);
			end
		end
		n_s9.c   = r_s8.c;
		n_s9.ok  = ok;
		n_s9.det = det;
		n_s9.un  = un;
		n_s9.vn  = vn;
		n_s9.tn  = tn;
	end

	// barycentric range test against det, no divide
	always_comb begin
		logic signed [INNER_W:0] suv, detx;
		inner_t un, vn, det;
		det  = r_s9.det;
		un   = r_s9.un;
		vn   = r_s9.vn;
		suv  = {un[INNER_W-1], un} + {vn[INNER_W-1], vn};
		detx = {det[INNER_W-1], det};
		n_s10.c   = r_s9.c;
		n_s10.ok  = r_s9.ok && un >= 0 && un <= det && vn >= 0 && suv <= detx;
		n_s10.det = det;
		n_s10.tn  = r_s9.tn;
	end

	always_comb begin
		n_s69.o  = side_q[DIV_LAT-1].c.o;
		n_s69.d  = side_q[DIV_LAT-1].c.d;
		n_s69.n  = side_q[DIV_LAT-1].c.n;
		n_s69.t  = t_div;
		n_s69.ok = side_q[DIV_LAT-1].ok
			&& t_div > ext_coord(side_q[DIV_LAT-1].c.tl)
			&& t_div < ext_coord(side_q[DIV_LAT-1].c.tu);
		for (int k = 0; k < 3; k++) begin
			za[k] = r_s69.t;
			zb[k] = ext_coord(r_s69.d[k]);
		end
	end

	always_comb begin
		n_rsp = '0;
		if (r_s71.ok) begin
			n_rsp.hit          = 1'b1;
			n_rsp.hit_distance = clamp_coord(r_s71.t);
			n_rsp.point_x      = clamp_coord(sat_add(ext_coord(r_s71.o[0]), zp[0]));
			n_rsp.point_y      = clamp_coord(sat_add(ext_coord(r_s71.o[1]), zp[1]));
			n_rsp.point_z      = clamp_coord(sat_add(ext_coord(r_s71.o[2]), zp[2]));
			n_rsp.normal_x     = clamp_coord(r_s71.n[0]);
			n_rsp.normal_y     = clamp_coord(r_s71.n[1]);
			n_rsp.normal_z     = clamp_coord(r_s71.n[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= head;
			e_s2 <= e_s1;
			e_s3 <= e_s2;
			r_s4 <= n_s4;
			c_s5 <= '{o: r_s4.e.o, d: r_s4.e.d, tl: r_s4.e.tl, tu: r_s4.e.tu, n: r_s4.n};
			c_s6 <= c_s5;
			r_s7.c <= c_s6;
			for (int j = 0; j < 4; j++) begin
				r_s7.ab[j] <= sat_add(yp[j*3], yp[j*3+1]);
				r_s7.cc[j] <= yp[j*3+2];
			end
			r_s8.c <= r_s7.c;
			for (int j = 0; j < 4; j++)
				r_s8.sum[j] <= sat_add(r_s7.ab[j], r_s7.cc[j]);
			r_s9  <= n_s9;
			r_s10 <= n_s10;
			side_q[0] <= '{c: r_s10.c, ok: r_s10.ok};
			for (int i = 1; i < DIV_LAT; i++)
				side_q[i] <= side_q[i-1];
			r_s69 <= n_s69;
			r_s70 <= r_s69;
			r_s71 <= r_s70;
			rsp_q <= n_rsp;
		end
	end

	for (genvar g = 0; g < N_XMUL; g++) begin : g_xmul
		rti_mul u_mul (.clk(clk), .en(en), .a(xa[g]), .b(xb[g]), .p(xp[g]));
	end

	for (genvar g = 0; g < N_YMUL; g++) begin : g_ymul
		rti_mul u_mul (.clk(clk), .en(en), .a(ya[g]), .b(yb[g]), .p(yp[g]));
	end

	for (genvar g = 0; g < N_ZMUL; g++) begin : g_zmul
		rti_mul u_mul (.clk(clk), .en(en), .a(za[g]), .b(zb[g]), .p(zp[g]));
	end

	rti_div u_div (
		.clk(clk),
		.en (en),
		.n  (r_s10.tn),
		.d  (r_s10.det),
		.q  (t_div)
	);

endmodule

// ===== design/ray_triangle_intersect_core.sv =====
// Top level: config registers, front end, test queue and back-end pipeline.
`timescale 1ns / 1ps
// Moller-Trumbore ray/triangle test in Q16.16. Load words write at most one
// vertex and give no result; each test word gives exactly one result word.
// The block takes one word per clock and returns one result per clock while
// the result side keeps up. A test is written into a four-word queue, then
// passes through the back-end pipeline before its result is presented; most
// of that pipeline is the divide for t, which resolves one quotient bit per
// stage over 56 stages, plus the registered multipliers for each product
// level. A stalled result holds the whole back end; the queue then absorbs
// up to four more tests before the request side is stalled.
module ray_triangle_intersect_core import rti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	qent_t             q_mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              full, push, take, pop, empty;
	qent_t             entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{cull_backfaces: 1'b0, det_epsilon: EPS_W'(1)};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CULL: cfg_q.cull_backfaces <= cfg_data[0];
				REG_EPS:  cfg_q.det_epsilon    <= cfg_data[EPS_W-1:0];
			endcase
		end
	end

	rti_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.full     (full),
		.push     (push),
		.entry    (entry)
	);

	assign empty = cnt_q == '0;
	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign pop   = take && !empty;

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	rti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(!empty),
		.head      (q_mem[rptr_q]),
		.take      (take),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("test queue count beyond depth");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.hit) |-> (rsp.hit_distance == '0 && rsp.point_x == '0
			&& rsp.point_y == '0 && rsp.point_z == '0 && rsp.normal_x == '0
			&& rsp.normal_y == '0 && rsp.normal_z == '0))
		else $error("miss word carries nonzero fields");

	a_hold_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> cnt_q >= $past(cnt_q))
		else $error("queue drained while back end stalled");
`endif

endmodule
